// ===== design/mbe_pkg.sv =====
// ---------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time iterator: request and result
// payloads, controller-to-datapath command, register map and number formats.
// ---------------------------------------------------------------------------
package mbe_pkg;

  // Number formats
  localparam int FRAC_BITS = 28;             // fraction bits of c, z and |z|^2
  localparam int C_W       = 32;             // signed Q4.FRAC point coordinates
  localparam int MAG_W     = 36;             // unsigned magnitudes and squares
  localparam int HALF_W    = 18;             // multiplier operand slice
  localparam int PP_W      = MAG_W + HALF_W; // one partial product
  localparam int PROD_W    = 2 * MAG_W;      // full square or cross product
  localparam int SUM_W     = MAG_W + 3;      // signed sum before saturation
  localparam int CNT_W     = 16;             // iteration counter

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  localparam logic REG_MAX_ITER = 1'b0;
  localparam logic REG_RADIUS   = 1'b1;

  localparam logic [CNT_W-1:0] MAX_ITER_RST = 16'd256;
  localparam logic [MAG_W-1:0] RADIUS_RST   = 36'h040000000;

  // Multiplier operand pairs
  localparam logic [1:0] MUL_RE_IM = 2'd0;
  localparam logic [1:0] MUL_RE_RE = 2'd1;
  localparam logic [1:0] MUL_IM_IM = 2'd2;

  typedef struct packed {
    logic signed [C_W-1:0] c_re;
    logic signed [C_W-1:0] c_im;
  } mbe_in_t;

  typedef struct packed {
    logic             escaped;
    logic [CNT_W-1:0] iteration_count;
    logic [MAG_W-1:0] escape_mag;
  } mbe_out_t;

  typedef struct packed {
    logic             init;        // load c, clear z and its squares
    logic [1:0]       mul_sel;
    logic             mul_hi;      // use upper slice of second operand
    logic             acc_load;
    logic             acc_add;
    logic             cross_ld;
    logic             z_ld;
    logic             re2_ld;
    logic             im2_ld;
    logic             res_ld;
    logic             res_escaped;
    logic [CNT_W-1:0] count;
  } mbe_cmd_t;

endpackage

// ===== design/mandelbrot_escape_iterator.sv =====
// ---------------------------------------------------------------------------
// mandelbrot_escape_iterator
// Escape-time iterator for one point c: z = z*z + c from z = 0 in fixed
// point, reporting escape, iteration index and |z|^2.
// ---------------------------------------------------------------------------
//  channel   signals                                  dir  meaning
//  request   start, busy, point{c_re,c_im}            in   taken when start && !busy
//  result    done, result{escaped,count,escape_mag}   out  valid for the done cycle
//  config    psel, penable, pwrite, paddr, pwdata,    in   limit at 0x0, radius^2 at 0x8
//            prdata, pready
//
// Each iteration forms three 36x36 products through one shared 36x18
// multiplier, two slices each, then saturation, z update and compare.
// done rises once iteration k+1 ends, k the escape index, or once limit
// iterations end when the point stays bounded (in the next cycle at limit 0).
// busy falls in the done cycle, so the next request may be taken there.
// rst is synchronous and restores the registers (limit 256, radius^2 4.0).
// Results cannot be stalled.
// ---------------------------------------------------------------------------
module mandelbrot_escape_iterator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  input  mbe_pkg::mbe_in_t            point,
  output logic                        busy,
  output logic                        done,
  output mbe_pkg::mbe_out_t           result
);

  logic [mbe_pkg::CNT_W-1:0] iter_limit;
  logic [mbe_pkg::MAG_W-1:0] esc_thresh;
  logic                      mag_gt;
  mbe_pkg::mbe_cmd_t         cmd;

  assign pready = 1'b1;

  mbe_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .iter_limit (iter_limit),
    .esc_thresh (esc_thresh)
  );

  mbe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .iter_limit (iter_limit),
    .mag_gt     (mag_gt),
    .busy       (busy),
    .done       (done),
    .cmd        (cmd)
  );

  mbe_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .point     (point),
    .radius_sq (esc_thresh),
    .mag_gt    (mag_gt),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  // a zero limit answers in the next cycle
  a_zero_limit: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && iter_limit == '0) |=> done)
    else $error("zero limit did not finish at once");

  // an escaped result lies above the radius and below the limit
  a_escape_mag: assert property (@(posedge clk) disable iff (rst)
    (done && result.escaped) |->
      (result.escape_mag > esc_thresh && result.iteration_count < iter_limit))
    else $error("escaped result inconsistent with configuration");

  // a bounded point reports the limit and a zero magnitude
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    (done && !result.escaped) |->
      (result.escape_mag == '0 && result.iteration_count == iter_limit))
    else $error("bounded result inconsistent with limit");

  // the result strobe comes only as the controller returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");
`endif

endmodule

// ===== design/mbe_regs.sv =====
// ---------------------------------------------------------------------------
// mbe_regs
// Configuration registers behind the APB-style port: iteration limit and
// escape radius squared, with read back.
// ---------------------------------------------------------------------------
module mbe_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::DATA_W-1:0]  prdata,
  output logic [mbe_pkg::CNT_W-1:0]   iter_limit,
  output logic [mbe_pkg::MAG_W-1:0]   esc_thresh
);

  logic wr_en;
  logic sel;

  assign wr_en = psel && penable && pwrite;
  assign sel   = paddr[mbe_pkg::ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit <= mbe_pkg::MAX_ITER_RST;
      esc_thresh <= mbe_pkg::RADIUS_RST;
    end else if (wr_en) begin
      if (sel == mbe_pkg::REG_MAX_ITER) begin
        iter_limit <= pwdata[mbe_pkg::CNT_W-1:0];
      end else begin
        esc_thresh <= pwdata[mbe_pkg::MAG_W-1:0];
      end
    end
  end

  always_comb begin
    if (sel == mbe_pkg::REG_MAX_ITER) begin
      prdata = mbe_pkg::DATA_W'(iter_limit);
    end else begin
      prdata = mbe_pkg::DATA_W'(esc_thresh);
    end
  end

endmodule

// ===== design/mbe_dp.sv =====
// ---------------------------------------------------------------------------
// mbe_dp
// Datapath: z in sign-magnitude form, one shared 36x18 multiplier with a
// 72-bit accumulator, saturating z update, |z|^2 compare and result register.
// ---------------------------------------------------------------------------
module mbe_dp (
  input  logic                       clk,
  input  mbe_pkg::mbe_cmd_t          cmd,
  input  mbe_pkg::mbe_in_t           point,
  input  logic [mbe_pkg::MAG_W-1:0]  radius_sq,
  output logic                       mag_gt,
  output mbe_pkg::mbe_out_t          result
);

  logic signed [mbe_pkg::C_W-1:0]    c_re;
  logic signed [mbe_pkg::C_W-1:0]    c_im;
  logic [mbe_pkg::MAG_W-1:0]         re_mag;
  logic [mbe_pkg::MAG_W-1:0]         im_mag;
  logic                              re_neg;
  logic                              im_neg;
  logic [mbe_pkg::MAG_W-1:0]         re2;
  logic [mbe_pkg::MAG_W-1:0]         im2;
  logic [mbe_pkg::MAG_W-1:0]         xprod;

  logic [mbe_pkg::MAG_W-1:0]         mul_a;
  logic [mbe_pkg::MAG_W-1:0]         mul_b;
  logic [mbe_pkg::HALF_W-1:0]        mul_b_half;
  logic [mbe_pkg::PP_W-1:0]          pp;
  logic [mbe_pkg::PROD_W-1:0]        acc;

  logic [mbe_pkg::PROD_W-1:0]        sh_sq;
  logic [mbe_pkg::PROD_W-1:0]        sh_x;
  logic [mbe_pkg::MAG_W-1:0]         sq_sat;
  logic [mbe_pkg::MAG_W-1:0]         x_sat;

  logic signed [mbe_pkg::SUM_W-1:0]  re_sum;
  logic signed [mbe_pkg::SUM_W-1:0]  im_sum;
  logic signed [mbe_pkg::SUM_W-1:0]  cross_s;
  logic [mbe_pkg::SUM_W-1:0]         re_abs;
  logic [mbe_pkg::SUM_W-1:0]         im_abs;
  logic [mbe_pkg::MAG_W-1:0]         re_mag_next;
  logic [mbe_pkg::MAG_W-1:0]         im_mag_next;

  logic [mbe_pkg::MAG_W:0]           mag_sum;
  logic [mbe_pkg::MAG_W-1:0]         mag;

  // Operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      mbe_pkg::MUL_RE_RE: begin
        mul_a = re_mag;
        mul_b = re_mag;
      end
      mbe_pkg::MUL_IM_IM: begin
        mul_a = im_mag;
        mul_b = im_mag;
      end
      default: begin
        mul_a = re_mag;
        mul_b = im_mag;
      end
    endcase
    mul_b_half = cmd.mul_hi ? mul_b[mbe_pkg::MAG_W-1:mbe_pkg::HALF_W]
                            : mul_b[mbe_pkg::HALF_W-1:0];
  end

  always_ff @(posedge clk) begin
    pp <= mbe_pkg::PP_W'(mul_a) * mbe_pkg::PP_W'(mul_b_half);
    if (cmd.acc_load) begin
      acc <= mbe_pkg::PROD_W'(pp);
    end else if (cmd.acc_add) begin
      acc <= acc + (mbe_pkg::PROD_W'(pp) << mbe_pkg::HALF_W);
    end
  end

  // Squares drop FRAC_BITS, the doubled cross product one fewer
  assign sh_sq  = acc >> mbe_pkg::FRAC_BITS;
  assign sh_x   = acc >> (mbe_pkg::FRAC_BITS - 1);
  assign sq_sat = (|sh_sq[mbe_pkg::PROD_W-1:mbe_pkg::MAG_W]) ? mbe_pkg::MAG_MAX
                                                              : sh_sq[mbe_pkg::MAG_W-1:0];
  assign x_sat  = (|sh_x[mbe_pkg::PROD_W-1:mbe_pkg::MAG_W]) ? mbe_pkg::MAG_MAX
                                                             : sh_x[mbe_pkg::MAG_W-1:0];

  // z update, saturated to +/-(2^36 - 1)
  always_comb begin
    cross_s = $signed({3'b000, xprod});
    if (re_neg ^ im_neg) begin
      cross_s = -cross_s;
    end
    re_sum = $signed({3'b000, re2}) - $signed({3'b000, im2})
           + mbe_pkg::SUM_W'(c_re);
    im_sum = cross_s + mbe_pkg::SUM_W'(c_im);
    re_abs = re_sum[mbe_pkg::SUM_W-1] ? unsigned'(-re_sum) : unsigned'(re_sum);
    im_abs = im_sum[mbe_pkg::SUM_W-1] ? unsigned'(-im_sum) : unsigned'(im_sum);
    re_mag_next = (|re_abs[mbe_pkg::SUM_W-1:mbe_pkg::MAG_W]) ? mbe_pkg::MAG_MAX
                                                             : re_abs[mbe_pkg::MAG_W-1:0];
    im_mag_next = (|im_abs[mbe_pkg::SUM_W-1:mbe_pkg::MAG_W]) ? mbe_pkg::MAG_MAX
                                                             : im_abs[mbe_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      c_re   <= point.c_re;
      c_im   <= point.c_im;
      re_mag <= '0;
      im_mag <= '0;
      re_neg <= 1'b0;
      im_neg <= 1'b0;
      re2    <= '0;
      im2    <= '0;
    end else begin
      if (cmd.z_ld) begin
        re_mag <= re_mag_next;
        im_mag <= im_mag_next;
        re_neg <= re_sum[mbe_pkg::SUM_W-1];
        im_neg <= im_sum[mbe_pkg::SUM_W-1];
      end
      if (cmd.re2_ld) begin
        re2 <= sq_sat;
      end
      if (cmd.im2_ld) begin
        im2 <= sq_sat;
      end
    end
    if (cmd.cross_ld) begin
      xprod <= x_sat;
    end
  end

  assign mag_sum = {1'b0, re2} + {1'b0, im2};
  assign mag     = mag_sum[mbe_pkg::MAG_W] ? mbe_pkg::MAG_MAX : mag_sum[mbe_pkg::MAG_W-1:0];
  assign mag_gt  = mag > radius_sq;

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      result.escaped         <= cmd.res_escaped;
      result.iteration_count <= cmd.count;
      result.escape_mag      <= cmd.res_escaped ? mag : '0;
    end
  end

endmodule

// ===== design/mbe_ctrl.sv =====
// ---------------------------------------------------------------------------
// mbe_ctrl
// Controller: accepts a request, runs the twelve-step schedule of one
// iteration on the datapath, counts iterations and decides escape or limit.
// ---------------------------------------------------------------------------
module mbe_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mbe_pkg::CNT_W-1:0]  iter_limit,
  input  logic                       mag_gt,
  output logic                       busy,
  output logic                       done,
  output mbe_pkg::mbe_cmd_t          cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [3:0] S_X_LO    = 4'd0;
  localparam logic [3:0] S_X_HI    = 4'd1;
  localparam logic [3:0] S_X_ACC   = 4'd2;
  localparam logic [3:0] S_X_SAT   = 4'd3;
  localparam logic [3:0] S_Z_UPD   = 4'd4;
  localparam logic [3:0] S_RE_LO   = 4'd5;
  localparam logic [3:0] S_RE_HI   = 4'd6;
  localparam logic [3:0] S_IM_LO   = 4'd7;
  localparam logic [3:0] S_IM_HI   = 4'd8;
  localparam logic [3:0] S_IM_ACC  = 4'd9;
  localparam logic [3:0] S_IM_SAT  = 4'd10;
  localparam logic [3:0] S_CHECK   = 4'd11;

  logic                      state;
  logic                      state_next;
  logic [3:0]                step;
  logic [3:0]                step_next;
  logic [mbe_pkg::CNT_W-1:0] iter;
  logic [mbe_pkg::CNT_W-1:0] iter_next;
  logic [mbe_pkg::CNT_W-1:0] iter_inc;
  logic                      done_next;

  assign busy     = (state == ST_RUN);
  assign iter_inc = iter + mbe_pkg::CNT_W'(1);

  always_comb begin
    state_next = state;
    step_next  = step;
    iter_next  = iter;
    done_next  = 1'b0;
    cmd        = '0;
    cmd.mul_sel = mbe_pkg::MUL_RE_IM;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.init = 1'b1;
          if (iter_limit == '0) begin
            // nothing to iterate: report the limit at once
            cmd.res_ld = 1'b1;
            cmd.count  = iter_limit;
            done_next  = 1'b1;
          end else begin
            state_next = ST_RUN;
            step_next  = S_X_LO;
            iter_next  = '0;
          end
        end
      end
      ST_RUN: begin
        step_next = step + 4'd1;
        case (step)
          S_X_LO: begin
            cmd.mul_sel = mbe_pkg::MUL_RE_IM;
          end
          S_X_HI: begin
            cmd.mul_sel  = mbe_pkg::MUL_RE_IM;
            cmd.mul_hi   = 1'b1;
            cmd.acc_load = 1'b1;
          end
          S_X_ACC: begin
            cmd.acc_add = 1'b1;
          end
          S_X_SAT: begin
            cmd.cross_ld = 1'b1;
          end
          S_Z_UPD: begin
            cmd.z_ld = 1'b1;
          end
          S_RE_LO: begin
            cmd.mul_sel = mbe_pkg::MUL_RE_RE;
          end
          S_RE_HI: begin
            cmd.mul_sel  = mbe_pkg::MUL_RE_RE;
            cmd.mul_hi   = 1'b1;
            cmd.acc_load = 1'b1;
          end
          S_IM_LO: begin
            cmd.mul_sel = mbe_pkg::MUL_IM_IM;
            cmd.acc_add = 1'b1;
          end
          S_IM_HI: begin
            cmd.mul_sel  = mbe_pkg::MUL_IM_IM;
            cmd.mul_hi   = 1'b1;
            cmd.acc_load = 1'b1;
            cmd.re2_ld   = 1'b1;
          end
          S_IM_ACC: begin
            cmd.acc_add = 1'b1;
          end
          S_IM_SAT: begin
            cmd.im2_ld = 1'b1;
          end
          S_CHECK: begin
            step_next = S_X_LO;
            if (mag_gt) begin
              cmd.res_ld      = 1'b1;
              cmd.res_escaped = 1'b1;
              cmd.count       = iter;
              done_next       = 1'b1;
              state_next      = ST_IDLE;
            end else if (iter_inc == iter_limit) begin
              cmd.res_ld = 1'b1;
              cmd.count  = iter_limit;
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end else begin
              iter_next = iter_inc;
            end
          end
          default: begin
            step_next  = S_X_LO;
            state_next = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= S_X_LO;
      iter  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      iter  <= iter_next;
      done  <= done_next;
    end
  end

endmodule

// ===== sim/tb_mandelbrot_escape_iterator.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_mandelbrot_escape_iterator
// Drives points into the escape-time iterator and checks every result
// against a table value or a fixed-point model of z = z*z + c. Starts with a table of corner
// points and register settings, then runs random phases. Each phase first
// drains the block, then programs the limit and radius^2 over APB and reads
// them back. Sender idling varies between phases.
// ---------------------------------------------------------------------------
module tb_mandelbrot_escape_iterator;

  localparam int N_DIRECTED   = 26;
  localparam int N_PHASES     = 12;
  localparam int PER_PHASE    = 46;
  localparam int DRAIN_CYCLES = 24;

  localparam logic signed [63:0] Z_LIM = 64'sh0000_000F_FFFF_FFFF;

  typedef enum logic {ROW_POINT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              reg_idx;
    logic [63:0]       wdata;
    mbe_pkg::mbe_in_t  pt;
    logic              known;
    mbe_pkg::mbe_out_t res;
  } row_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [mbe_pkg::ADDR_W-1:0] paddr;
  logic [mbe_pkg::DATA_W-1:0] pwdata;
  logic [mbe_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       start;
  mbe_pkg::mbe_in_t           point;
  logic                       busy;
  logic                       done;
  mbe_pkg::mbe_out_t          result;

  logic [mbe_pkg::CNT_W-1:0]  limit_cfg;
  logic [mbe_pkg::MAG_W-1:0]  radius_cfg;
  mbe_pkg::mbe_out_t          pending_escapes[$];
  int                         mismatch_count;

  mandelbrot_escape_iterator u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .point   (point),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Escape-time model
  // -------------------------------------------------------------------------
  function automatic logic [mbe_pkg::MAG_W-1:0] scaled_product(
      logic [mbe_pkg::MAG_W-1:0] a, logic [mbe_pkg::MAG_W-1:0] b, int unsigned sh);
    logic [mbe_pkg::PROD_W-1:0] prod;
    prod = mbe_pkg::PROD_W'(a) * mbe_pkg::PROD_W'(b);
    prod = prod >> sh;
    return (prod > mbe_pkg::PROD_W'(mbe_pkg::MAG_MAX)) ? mbe_pkg::MAG_MAX
                                                      : prod[mbe_pkg::MAG_W-1:0];
  endfunction

  function automatic logic [mbe_pkg::MAG_W-1:0] abs_z(logic signed [63:0] v);
    return (v < 0) ? mbe_pkg::MAG_W'(-v) : mbe_pkg::MAG_W'(v);
  endfunction

  function automatic logic signed [63:0] clamp_z(logic signed [63:0] v);
    if (v > Z_LIM) return Z_LIM;
    if (v < -Z_LIM) return -Z_LIM;
    return v;
  endfunction

  function automatic mbe_pkg::mbe_out_t predict_escape(mbe_pkg::mbe_in_t p);
    logic signed [63:0]        cr, ci, zr, zi, cross_s, zr_next;
    logic [mbe_pkg::MAG_W-1:0] re2, im2, xprod;
    logic [mbe_pkg::MAG_W:0]   mag;
    mbe_pkg::mbe_out_t         r;
    int unsigned               i;
    cr = {{32{p.c_re[mbe_pkg::C_W-1]}}, p.c_re};
    ci = {{32{p.c_im[mbe_pkg::C_W-1]}}, p.c_im};
    zr = '0;
    zi = '0;
    r = '0;
    r.iteration_count = limit_cfg;
    for (i = 0; i < limit_cfg; i++) begin
      re2 = scaled_product(abs_z(zr), abs_z(zr), mbe_pkg::FRAC_BITS);
      im2 = scaled_product(abs_z(zi), abs_z(zi), mbe_pkg::FRAC_BITS);
      xprod = scaled_product(abs_z(zr), abs_z(zi), mbe_pkg::FRAC_BITS - 1);
      cross_s = {28'd0, xprod};
      if ((zr < 0) != (zi < 0)) cross_s = -cross_s;
      zr_next = {28'd0, re2};
      zr_next = zr_next - {28'd0, im2} + cr;
      zr = clamp_z(zr_next);
      zi = clamp_z(cross_s + ci);
      re2 = scaled_product(abs_z(zr), abs_z(zr), mbe_pkg::FRAC_BITS);
      im2 = scaled_product(abs_z(zi), abs_z(zi), mbe_pkg::FRAC_BITS);
      mag = {1'b0, re2} + {1'b0, im2};
      if (mag > {1'b0, mbe_pkg::MAG_MAX}) mag = {1'b0, mbe_pkg::MAG_MAX};
      if (mag[mbe_pkg::MAG_W-1:0] > radius_cfg) begin
        r.escaped = 1'b1;
        r.iteration_count = i[mbe_pkg::CNT_W-1:0];
        r.escape_mag = mag[mbe_pkg::MAG_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus table helpers
  // -------------------------------------------------------------------------
  function automatic row_t point_row(logic [mbe_pkg::C_W-1:0] re,
                                     logic [mbe_pkg::C_W-1:0] im);
    row_t r;
    r = '0;
    r.kind = ROW_POINT;
    r.pt.c_re = re;
    r.pt.c_im = im;
    return r;
  endfunction

  function automatic row_t known_row(logic [mbe_pkg::C_W-1:0] re,
                                     logic [mbe_pkg::C_W-1:0] im,
                                     logic esc, logic [mbe_pkg::CNT_W-1:0] cnt,
                                     logic [mbe_pkg::MAG_W-1:0] mag);
    row_t r;
    r = point_row(re, im);
    r.known = 1'b1;
    r.res.escaped = esc;
    r.res.iteration_count = cnt;
    r.res.escape_mag = mag;
    return r;
  endfunction

  function automatic row_t cfg_row(logic idx, logic [63:0] d);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.wdata = d;
    return r;
  endfunction

  function automatic mbe_pkg::mbe_in_t random_point();
    mbe_pkg::mbe_in_t p;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // the interesting region, |c_re|, |c_im| <= 2.0
      p.c_re = $urandom_range(32'h4000_0000) - 32'h2000_0000;
      p.c_im = $urandom_range(32'h4000_0000) - 32'h2000_0000;
    end else if (pick < 85) begin
      p.c_re = $urandom_range(32'h1000_0000) - 32'h0800_0000;
      p.c_im = $urandom_range(32'h1000_0000) - 32'h0800_0000;
    end else begin
      p.c_re = $urandom;
      p.c_im = $urandom;
    end
    return p;
  endfunction

  function automatic logic [mbe_pkg::MAG_W-1:0] random_radius();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return mbe_pkg::RADIUS_RST;
    if (pick < 75) return mbe_pkg::MAG_W'($urandom_range(32'h4000_0000));
    if (pick < 90) return {4'($urandom), 32'($urandom)};
    if (pick < 95) return mbe_pkg::MAG_MAX;
    return '0;
  endfunction

  // -------------------------------------------------------------------------
  // Bus tasks
  // -------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic idx, input logic [63:0] d,
                          output logic [63:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, track it in the model, then read it back.
  task automatic program_reg(input logic idx, input logic [63:0] d);
    logic [63:0] rd;
    apb_xfer(1'b1, idx, d, rd);
    case (idx)
      mbe_pkg::REG_MAX_ITER: limit_cfg = d[mbe_pkg::CNT_W-1:0];
      mbe_pkg::REG_RADIUS:   radius_cfg = d[mbe_pkg::MAG_W-1:0];
      default: ;
    endcase
    apb_xfer(1'b0, idx, '0, rd);
    case (idx)
      mbe_pkg::REG_MAX_ITER:
        if (rd[mbe_pkg::CNT_W-1:0] !== limit_cfg) begin
          $error("iteration limit readback: expected %0d, got %0d",
                 limit_cfg, rd[mbe_pkg::CNT_W-1:0]);
          mismatch_count++;
        end
      mbe_pkg::REG_RADIUS:
        if (rd[mbe_pkg::MAG_W-1:0] !== radius_cfg) begin
          $error("radius readback: expected %h, got %h",
                 radius_cfg, rd[mbe_pkg::MAG_W-1:0]);
          mismatch_count++;
        end
      default: ;
    endcase
  endtask

  // Present a request and hold it until taken; record the expected result.
  task automatic send_point(input mbe_pkg::mbe_in_t p, input logic known,
                            input mbe_pkg::mbe_out_t known_res);
    @(negedge clk);
    start <= 1'b1;
    point <= p;
    do @(posedge clk); while (busy);
    pending_escapes.push_back(known ? known_res : predict_escape(p));
  endtask

  task automatic hold_off(input int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Result checker
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    mbe_pkg::mbe_out_t want;
    if (!rst && done) begin
      if (pending_escapes.size() == 0) begin
        $error("result with no pending request: escaped %0d count %0d mag %h",
               result.escaped, result.iteration_count, result.escape_mag);
        mismatch_count++;
      end else begin
        want = pending_escapes.pop_front();
        if (result.escaped !== want.escaped) begin
          $error("escaped: expected %0d, got %0d", want.escaped, result.escaped);
          mismatch_count++;
        end
        if (result.iteration_count !== want.iteration_count) begin
          $error("iteration_count: expected %0d, got %0d",
                 want.iteration_count, result.iteration_count);
          mismatch_count++;
        end
        if (result.escape_mag !== want.escape_mag) begin
          $error("escape_mag: expected %h, got %h",
                 want.escape_mag, result.escape_mag);
          mismatch_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    row_t        directed_rows [N_DIRECTED];
    int          r, phase, k;
    int unsigned idle_pct;
    logic [63:0] wdata;

    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    start      = 1'b0;
    point      = '0;
    limit_cfg  = mbe_pkg::MAX_ITER_RST;
    radius_cfg = mbe_pkg::RADIUS_RST;
    mismatch_count = 0;

    directed_rows = '{
      // reset settings: limit 256, radius^2 4.0
      known_row(32'h0000_0000, 32'h0000_0000, 1'b0, 16'd256, 36'h0),
      known_row(32'h2000_0000, 32'h0000_0000, 1'b1, 16'd1, 36'h240000000),
      known_row(32'hE000_0000, 32'h0000_0000, 1'b0, 16'd256, 36'h0),
      known_row(32'h8000_0000, 32'h0000_0000, 1'b1, 16'd0, 36'h400000000),
      known_row(32'h0000_0000, 32'h8000_0000, 1'b1, 16'd0, 36'h400000000),
      point_row(32'h7FFF_FFFF, 32'h7FFF_FFFF),
      point_row(32'h8000_0000, 32'h7FFF_FFFF),
      point_row(32'h7FFF_FFFF, 32'h8000_0000),
      point_row(32'h0400_0000, 32'h0800_0000),
      point_row(32'hF400_0000, 32'h0199_9999),
      // zero limit: no iteration runs
      cfg_row(mbe_pkg::REG_MAX_ITER, 64'hFFFF_FFFF_FFFF_0000),
      known_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0, 36'h0),
      known_row(32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0, 36'h0),
      // full limit, zero radius: any nonzero |z|^2 escapes at once
      cfg_row(mbe_pkg::REG_MAX_ITER, 64'h1234_5678_9ABC_FFFF),
      cfg_row(mbe_pkg::REG_RADIUS, 64'hFFFF_FFF0_0000_0000),
      known_row(32'h1000_0000, 32'h0000_0000, 1'b1, 16'd0, 36'h010000000),
      known_row(32'h0000_0000, 32'h0000_4000, 1'b1, 16'd0, 36'h000000001),
      // saturated radius: nothing escapes
      cfg_row(mbe_pkg::REG_MAX_ITER, 64'd7),
      cfg_row(mbe_pkg::REG_RADIUS, 64'hFFFF_FFFF_FFFF_FFFF),
      known_row(32'h8000_0000, 32'h8000_0000, 1'b0, 16'd7, 36'h0),
      known_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd7, 36'h0),
      known_row(32'h0000_0000, 32'h0000_0000, 1'b0, 16'd7, 36'h0),
      // single iteration, |z|^2 equal to the radius does not escape
      cfg_row(mbe_pkg::REG_MAX_ITER, 64'd1),
      cfg_row(mbe_pkg::REG_RADIUS, 64'(mbe_pkg::RADIUS_RST)),
      known_row(32'h8000_0000, 32'h0000_0000, 1'b1, 16'd0, 36'h400000000),
      known_row(32'h2000_0000, 32'h0000_0000, 1'b0, 16'd1, 36'h0)
    };

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        program_reg(directed_rows[r].reg_idx, directed_rows[r].wdata);
      end else begin
        send_point(directed_rows[r].pt, directed_rows[r].known,
                   directed_rows[r].res);
      end
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase / 4)
        0:       idle_pct = 14;
        1:       idle_pct = 49;
        default: idle_pct = 0;
      endcase
      wait_idle();
      wdata = {$urandom, $urandom};
      // keep most limits short; one phase runs the reset limit
      wdata[mbe_pkg::CNT_W-1:0] = (phase == 5) ? mbe_pkg::MAX_ITER_RST
                                               : mbe_pkg::CNT_W'($urandom_range(48));
      program_reg(mbe_pkg::REG_MAX_ITER, wdata);
      wdata = {$urandom, $urandom};
      wdata[mbe_pkg::MAG_W-1:0] = random_radius();
      program_reg(mbe_pkg::REG_RADIUS, wdata);
      for (k = 0; k < PER_PHASE; k++) begin
        send_point(random_point(), 1'b0, '0);
        if ($urandom_range(99) < 3) wait_idle();
        else if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 40));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_escapes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
